// ===== src/hsl_pkg.sv =====
// ----------------------------------------------------------------------------
// hsl_pkg
// shared constants and types for the hsl to rgb converter pipeline
// ----------------------------------------------------------------------------
package hsl_pkg;

    // default number of fraction bits, one = 2**frac_bits
    localparam int DEF_FRAC_BITS = 16;

    // piece of the hue ramp that a channel falls on
    typedef enum logic [1:0] {
        SEG_RISE = 2'd0,
        SEG_TOP  = 2'd1,
        SEG_FALL = 2'd2,
        SEG_BASE = 2'd3
    } ramp_seg_t;

    // stage load enables handed from the top level to each lane
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

endpackage

// ===== src/hsl_ramp_lane.sv =====
// ----------------------------------------------------------------------------
// hsl_ramp_lane
// one color channel: hue segment and ramp factor, ramp product, final select
// ----------------------------------------------------------------------------
module hsl_ramp_lane #(
    parameter int FRAC_BITS = hsl_pkg::DEF_FRAC_BITS
) (
    input  logic                 clk,
    input  hsl_pkg::pipe_en_t    en,
    input  logic [FRAC_BITS-1:0] t,
    input  logic [FRAC_BITS:0]   qp_diff,
    input  logic [FRAC_BITS:0]   p,
    input  logic [FRAC_BITS:0]   q,
    output logic [FRAC_BITS:0]   chan
);
    import hsl_pkg::*;

    localparam int VW  = FRAC_BITS + 1;
    localparam int FW  = FRAC_BITS + 3;
    localparam int PRW = 2 * FRAC_BITS + 2;
    localparam int MW  = FRAC_BITS + 2;
    localparam int SW  = FRAC_BITS + 3;

    localparam logic [VW-1:0]        ONE        = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS-1:0] SIXTH      = FRAC_BITS'((1 << FRAC_BITS) / 6);
    localparam logic [FRAC_BITS-1:0] HALF       = FRAC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [FRAC_BITS-1:0] TWO_THIRDS = FRAC_BITS'((2 * (1 << FRAC_BITS)) / 3);

    ramp_seg_t       seg2_reg, seg2_next;
    logic [VW-1:0]   fac2_reg, fac2_next;
    ramp_seg_t       seg3_reg;
    logic [MW-1:0]   prod3_reg, prod3_next;
    logic [VW-1:0]   chan_reg, chan_next;

    logic [FW-1:0]   rise_fac;
    logic [FW-1:0]   fall_fac;
    logic [PRW-1:0]  prod_full;
    logic [SW-1:0]   ramp_sum;
    logic [VW-1:0]   ramp_val;

    // segment and scale factor of the shifted hue
    always_comb
    begin
        rise_fac = FW'(t) * FW'(6);
        fall_fac = FW'(TWO_THIRDS - t) * FW'(6);
        if (t < SIXTH)
        begin
            seg2_next = SEG_RISE;
            fac2_next = rise_fac[VW-1:0];
        end
        else if (t < HALF)
        begin
            seg2_next = SEG_TOP;
            fac2_next = '0;
        end
        else if (t < TWO_THIRDS)
        begin
            seg2_next = SEG_FALL;
            fac2_next = fall_fac[VW-1:0];
        end
        else
        begin
            seg2_next = SEG_BASE;
            fac2_next = '0;
        end
    end

    // (q - p) times factor, truncated
    always_comb
    begin
        prod_full  = PRW'(qp_diff) * PRW'(fac2_reg);
        prod3_next = prod_full[PRW-1:FRAC_BITS];
    end

    always_comb
    begin
        ramp_sum = SW'(p) + SW'(prod3_reg);
        ramp_val = (ramp_sum > SW'(ONE)) ? ONE : ramp_sum[VW-1:0];
        case (seg3_reg)
            SEG_RISE: chan_next = ramp_val;
            SEG_FALL: chan_next = ramp_val;
            SEG_TOP:  chan_next = q;
            SEG_BASE: chan_next = p;
            default:  chan_next = p;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            seg2_reg <= seg2_next;
            fac2_reg <= fac2_next;
        end
        if (en.s3)
        begin
            seg3_reg  <= seg2_reg;
            prod3_reg <= prod3_next;
        end
        if (en.s4)
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

// ===== src/hsl_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// hsl plus alpha to rgb plus alpha, unsigned fixed point, four stage pipeline
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid, in_ready  | hue, saturation, lightness, alpha_in
//  out     | out_valid, out_ready| red, green, blue, alpha_out
//
//  one beat per clock in steady state while out_ready stays high
//  the stages are: s1 l*s product, s2 q/p and hue segment,
//  s3 ramp products, s4 add, clamp and select into the output register
//  reset clears only the stage valid bits; data registers are not reset
//  a stall at out_ready freezes only the stages that hold a beat; empty
//  stages keep filling, so no beat is dropped or repeated
//
module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = hsl_pkg::DEF_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input beat
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FRAC_BITS-1:0] hue,
    input  logic [FRAC_BITS:0]   saturation,
    input  logic [FRAC_BITS:0]   lightness,
    input  logic [FRAC_BITS:0]   alpha_in,
    // output beat
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FRAC_BITS:0]   red,
    output logic [FRAC_BITS:0]   green,
    output logic [FRAC_BITS:0]   blue,
    output logic [FRAC_BITS:0]   alpha_out
);
    import hsl_pkg::*;

    localparam int VW  = FRAC_BITS + 1;      // 0..one
    localparam int QW  = FRAC_BITS + 2;      // 0..2*one
    localparam int LSW = 2 * FRAC_BITS + 1;  // l*s product

    localparam logic [VW-1:0]        ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [VW-1:0]        HALF  = VW'(1) << (FRAC_BITS - 1);
    localparam logic [FRAC_BITS-1:0] THIRD = FRAC_BITS'((1 << FRAC_BITS) / 3);

    // stage valid bits and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic en1, en2, en3, en4;
    pipe_en_t lane_en;

    // stage 1: saturated inputs, l*s, shifted hues
    logic [VW-1:0]        s_sat, l_sat;
    logic [VW-1:0]        s1_reg, l1_reg;
    logic [LSW-1:0]       ls1_reg, ls1_next;
    logic [FRAC_BITS-1:0] hue_r1_reg, hue_r1_next;
    logic [FRAC_BITS-1:0] hue_g1_reg;
    logic [FRAC_BITS-1:0] hue_b1_reg, hue_b1_next;

    // stage 2: q, p and q - p
    logic [VW-1:0]        ls_hi;
    logic [QW-1:0]        q_raw, two_l, p_raw;
    logic [VW-1:0]        q2_reg, q2_next;
    logic [VW-1:0]        p2_reg, p2_next;
    logic [VW-1:0]        d2_reg, d2_next;

    // stage 3: p and q kept beside the ramp products
    logic [VW-1:0]        q3_reg, p3_reg;

    // alpha rides along untouched
    logic [VW-1:0]        a1_reg, a2_reg, a3_reg, a4_reg;

    // ------------------------------------------------------------------------
    // flow control: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------------
    always_comb
    begin
        en4 = !v4_reg || out_ready;
        en3 = !v3_reg || en4;
        en2 = !v2_reg || en3;
        en1 = !v1_reg || en2;

        v1_next = en1 ? in_valid : v1_reg;
        v2_next = en2 ? v1_reg   : v2_reg;
        v3_next = en3 ? v2_reg   : v3_reg;
        v4_next = en4 ? v3_reg   : v4_reg;

        lane_en.s2 = en2;
        lane_en.s3 = en3;
        lane_en.s4 = en4;
    end

    assign in_ready  = en1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: clamp s and l to one, multiply, offset hue by a third turn
    // ------------------------------------------------------------------------
    always_comb
    begin
        s_sat       = (saturation > ONE) ? ONE : saturation;
        l_sat       = (lightness > ONE) ? ONE : lightness;
        ls1_next    = LSW'(s_sat) * LSW'(l_sat);
        // hue wraps modulo one turn through the natural field width
        hue_r1_next = hue + THIRD;
        hue_b1_next = hue - THIRD;
    end

    // ------------------------------------------------------------------------
    // stage 2: q = l + l*s below half, else l + s - l*s; p = 2l - q
    // zero saturation needs no special path: l*s is zero, so q = p = l
    // and every channel comes out equal to lightness
    // ------------------------------------------------------------------------
    always_comb
    begin
        ls_hi = ls1_reg[LSW-1:FRAC_BITS];
        if (l1_reg < HALF)
        begin
            q_raw = QW'(l1_reg) + QW'(ls_hi);
        end
        else
        begin
            q_raw = QW'(l1_reg) + QW'(s1_reg) - QW'(ls_hi);
        end
        q2_next = (q_raw > QW'(ONE)) ? ONE : q_raw[VW-1:0];

        two_l = QW'(l1_reg) << 1;
        p_raw = (two_l < QW'(q2_next)) ? '0 : two_l - QW'(q2_next);
        p2_next = (p_raw > QW'(ONE)) ? ONE : p_raw[VW-1:0];

        d2_next = (q2_next > p2_next) ? q2_next - p2_next : '0;
    end

    // ------------------------------------------------------------------------
    // payload registers, no reset
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg     <= s_sat;
            l1_reg     <= l_sat;
            ls1_reg    <= ls1_next;
            hue_r1_reg <= hue_r1_next;
            hue_g1_reg <= hue;
            hue_b1_reg <= hue_b1_next;
            a1_reg     <= alpha_in;
        end
        if (en2)
        begin
            q2_reg <= q2_next;
            p2_reg <= p2_next;
            d2_reg <= d2_next;
            a2_reg <= a1_reg;
        end
        if (en3)
        begin
            q3_reg <= q2_reg;
            p3_reg <= p2_reg;
            a3_reg <= a2_reg;
        end
        if (en4)
        begin
            a4_reg <= a3_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stages 2 to 4 of each channel: segment, product, select
    // ------------------------------------------------------------------------
    hsl_ramp_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_red (
        .clk     (clk),
        .en      (lane_en),
        .t       (hue_r1_reg),
        .qp_diff (d2_reg),
        .p       (p3_reg),
        .q       (q3_reg),
        .chan    (red)
    );

    hsl_ramp_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_green (
        .clk     (clk),
        .en      (lane_en),
        .t       (hue_g1_reg),
        .qp_diff (d2_reg),
        .p       (p3_reg),
        .q       (q3_reg),
        .chan    (green)
    );

    hsl_ramp_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_blue (
        .clk     (clk),
        .en      (lane_en),
        .t       (hue_b1_reg),
        .qp_diff (d2_reg),
        .p       (p3_reg),
        .q       (q3_reg),
        .chan    (blue)
    );

    assign alpha_out = a4_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // an accepted beat always lands in stage 1
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted beat missing from stage 1");

    // a stage 1 beat that cannot move on keeps its data
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en2) |=> (v1_reg && $stable(ls1_reg) && $stable(hue_g1_reg)))
        else $error("stage 1 beat lost or changed under stall");

    // lightness lies between p and q, so q never falls below p
    a_q_above_p: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (q2_reg >= p2_reg))
        else $error("q below p in stage 2");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for hsl_to_rgb_converter: drives hsl colors over the
// valid/ready input, predicts each rgb result in a scoreboard and compares
// every output beat field by field, under three sender/receiver stall mixes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import hsl_pkg::*;

    localparam int     FB          = DEF_FRAC_BITS;
    localparam longint ONE         = longint'(1) << FB;
    localparam longint HUE_MASK    = ONE - 1;
    localparam longint THIRD       = ONE / 3;
    localparam longint SIXTH       = ONE / 6;
    localparam longint HALF        = ONE / 2;
    localparam longint TWO_THIRDS  = (2 * ONE) / 3;
    localparam longint FIELD_MAX   = 2 * ONE - 1;   // all ones in a 17-bit field
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     DRAIN_WAIT  = 16;            // pipeline is four deep
    localparam int     RANDOM_BEATS = 430;          // per phase

    // one output beat
    typedef struct packed {
        logic [FB:0] red;
        logic [FB:0] green;
        logic [FB:0] blue;
        logic [FB:0] alpha;
    } rgba_t;

    // ------------------------------------------------------------------
    // scoreboard: fifo of predicted colors, one entry per input beat
    // ------------------------------------------------------------------
    class color_scoreboard;
        rgba_t       pending_q[$];
        int unsigned errors;

        function void note_input(rgba_t c);
            pending_q.push_back(c);
        endfunction

        function void compare_field(string name, logic [FB:0] want, logic [FB:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(rgba_t got);
            rgba_t want;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual r=%0d g=%0d b=%0d a=%0d",
                         $time, got.red, got.green, got.blue, got.alpha);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("alpha", want.alpha, got.alpha);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // dut signals, every input driven by the bench known from time zero
    // ------------------------------------------------------------------
    logic          clk        = 1'b0;
    logic          rst_n      = 1'b0;
    logic          in_valid   = 1'b0;
    logic          in_ready;
    logic [FB-1:0] hue        = '0;
    logic [FB:0]   saturation = '0;
    logic [FB:0]   lightness  = '0;
    logic [FB:0]   alpha_in   = '0;
    logic          out_valid;
    logic          out_ready  = 1'b0;
    logic [FB:0]   red;
    logic [FB:0]   green;
    logic [FB:0]   blue;
    logic [FB:0]   alpha_out;

    color_scoreboard sb;
    int              send_idle_pct = 0;   // chance in percent of a gap before a beat
    int              recv_idle_pct = 0;   // chance in percent of out_ready low
    int unsigned     cycle_count   = 0;

    hsl_to_rgb_converter #(.FRAC_BITS(FB)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .alpha_in   (alpha_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha_out  (alpha_out)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // color math, fixed point with FB fraction bits
    // ------------------------------------------------------------------

    // keep a value inside 0..one
    function automatic longint clamp_unit(longint v);
        if (v < 0)
            return 0;
        if (v > ONE)
            return ONE;
        return v;
    endfunction

    // level of one channel on the hue ramp; t is the channel's shifted hue
    function automatic longint ramp_level(longint p, longint q, longint t);
        longint d;
        longint v;
        d = (q > p) ? q - p : 0;
        if (t < SIXTH)
            v = p + ((d * 6 * t) >> FB);          // rising edge
        else if (t < HALF)
            v = q;                                 // plateau
        else if (t < TWO_THIRDS)
            v = p + ((d * ((TWO_THIRDS - t) * 6)) >> FB);  // falling edge
        else
            v = p;                                 // floor
        return (v > ONE) ? ONE : v;
    endfunction

    function automatic rgba_t hsl_to_rgba(logic [FB-1:0] h_in, logic [FB:0] s_in,
                                          logic [FB:0] l_in, logic [FB:0] a_in);
        longint h;
        longint s;
        longint l;
        longint q;
        longint p;
        rgba_t  c;
        h = longint'(h_in);
        s = longint'(s_in);
        l = longint'(l_in);
        // out-of-range saturation and lightness saturate to one
        if (s > ONE)
            s = ONE;
        if (l > ONE)
            l = ONE;
        c.alpha = a_in;
        if (s == 0)
        begin
            // grey
            c.red   = (FB+1)'(l);
            c.green = (FB+1)'(l);
            c.blue  = (FB+1)'(l);
        end
        else
        begin
            if (l < HALF)
                q = (l * (ONE + s)) >> FB;
            else
                q = l + s - ((l * s) >> FB);
            q = clamp_unit(q);
            p = clamp_unit(2 * l - q);
            // red leads by a third of a turn, blue lags by a third, both wrap
            c.red   = (FB+1)'(ramp_level(p, q, (h + THIRD) & HUE_MASK));
            c.green = (FB+1)'(ramp_level(p, q, h));
            c.blue  = (FB+1)'(ramp_level(p, q, (h + ONE - THIRD) & HUE_MASK));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // random field values
    // ------------------------------------------------------------------

    // saturation or lightness, weighted toward the extremes, half and out of range
    function automatic logic [FB:0] rand_unit();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return (FB+1)'(ONE);
            2:       return (FB+1)'($urandom_range(0, FIELD_MAX));
            3:       return (FB+1)'(HALF - 2 + $urandom_range(0, 4));
            default: return (FB+1)'($urandom_range(0, ONE));
        endcase
    endfunction

    // hue close to a ramp segment edge as seen by one of the three channels
    function automatic logic [FB-1:0] hue_near_edge();
        longint seg_edge;
        longint shift;
        longint v;
        case ($urandom_range(0, 3))
            0:       seg_edge = 0;
            1:       seg_edge = SIXTH;
            2:       seg_edge = HALF;
            default: seg_edge = TWO_THIRDS;
        endcase
        case ($urandom_range(0, 2))
            0:       shift = 0;
            1:       shift = THIRD;
            default: shift = ONE - THIRD;
        endcase
        v = seg_edge - shift + longint'($urandom_range(0, 4)) - 2 + 2 * ONE;
        return FB'(v & HUE_MASK);
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // present one beat and hold it until accepted, then log the prediction
    task automatic send_color(input logic [FB-1:0] h, input logic [FB:0] s,
                              input logic [FB:0] l, input logic [FB:0] a);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        lightness  <= l;
        alpha_in   <= a;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(hsl_to_rgba(h, s, l, a));
    endtask

    // directed beat given as plain numbers, cut to the field widths
    task automatic send_fixed(input longint h, input longint s,
                              input longint l, input longint a);
        send_color(FB'(h), (FB+1)'(s), (FB+1)'(l), (FB+1)'(a));
    endtask

    task automatic send_random_color();
        logic [FB-1:0] h;
        logic [FB:0]   a;
        h = ($urandom_range(0, 9) < 3) ? hue_near_edge() : FB'($urandom_range(0, HUE_MASK));
        a = ($urandom_range(0, 9) == 0) ? (FB+1)'($urandom_range(0, FIELD_MAX))
                                        : (FB+1)'($urandom_range(0, ONE));
        send_color(h, rand_unit(), rand_unit(), a);
    endtask

    // hold off the sender until every predicted color has come out
    task automatic wait_for_drain();
        if (sb.pending_q.size() != 0)
        begin
            in_valid <= 1'b0;
            while (sb.pending_q.size() != 0)
                @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // output side: sample the beat, then pick the next out_ready
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(rgba_t'{red, green, blue, alpha_out});
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            // receiver idles most first, then the sender, then full rate
            case (phase)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 73;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_idle_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0)
            begin
                // field extremes
                send_fixed(0, 0, 0, 0);
                send_fixed(HUE_MASK, ONE, ONE, ONE);
                // primaries at full saturation, mid lightness
                send_fixed(0, ONE, HALF, ONE);
                send_fixed(THIRD, ONE, HALF, ONE);
                send_fixed(TWO_THIRDS, ONE, HALF, 1234);
                // red offset lands exactly on a full turn and wraps to zero
                send_fixed(ONE - THIRD, ONE, HALF, 777);
                // green on both sides of the first two segment edges, just below the last
                send_fixed(SIXTH - 1, ONE, HALF, 1);
                send_fixed(SIXTH, ONE, HALF, 2);
                send_fixed(HALF - 1, 40000, 20000, 3);
                send_fixed(HALF, 40000, 20000, 4);
                send_fixed(TWO_THIRDS - 1, 50000, 45000, 5);
                // grey, zero saturation
                send_fixed(12345, 0, 40000, 9999);
                // saturation and lightness above one
                send_fixed(20000, FIELD_MAX, 20000, ONE);
                send_fixed(5000, 30000, FIELD_MAX, ONE);
                // lightness just under and at one half
                send_fixed(7000, 50000, HALF - 1, 100);
                send_fixed(7000, 50000, HALF, 100);
                // alpha above one passes through
                send_fixed(0, 0, 0, FIELD_MAX);
                // smallest nonzero saturation, lightness and alpha
                send_fixed(HUE_MASK, 1, 1, 1);
                // black and white at full saturation
                send_fixed(12345, ONE, 0, 0);
                send_fixed(54321, ONE, ONE, ONE);
                send_fixed(30000, ONE - 1, ONE - 1, ONE - 1);
                // alternating bit patterns
                send_fixed('h5555, 'h1ffff, 'h1ffff, 'h15555);
                send_fixed('haaaa, 'h0aaaa, 'h0aaaa, 'h0aaaa);
            end

            for (int n = 0; n < RANDOM_BEATS; n++)
            begin
                // occasional full drain in the middle of a phase
                if ($urandom_range(0, 199) == 0)
                    wait_for_drain();
                send_random_color();
            end
            wait_for_drain();
        end

        // let any stray beat show up before the verdict
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/hsl_pkg.sv
src/hsl_ramp_lane.sv
src/hsl_to_rgb_converter.sv
dv/tb.sv
